/* src/aazd_pkg.sv */
// ----------------------------------------------------------------------------
// aazd_pkg
// Shared types and constants for the adc average / zone debounce block.
// ----------------------------------------------------------------------------
package aazd_pkg;

  // result and threshold widths are fixed by the register map
  localparam int unsigned AVG_W  = 13;
  localparam int unsigned THR_W  = 13;
  localparam int unsigned RUN_W  = 5;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = 3;

  typedef logic [AVG_W-1:0]  avg_t;
  typedef logic [THR_W-1:0]  thr_t;
  typedef logic [RUN_W-1:0]  run_t;
  typedef logic [MODE_W-1:0] mode_t;
  typedef logic [IDX_W-1:0]  reg_idx_t;

  // operating modes; the unused code behaves as single-ended
  localparam mode_t MODE_CLASSIFY = 2'd0;
  localparam mode_t MODE_SINGLE   = 2'd1;
  localparam mode_t MODE_DIFF     = 2'd2;

  // register indexes (byte address = 4 * index)
  localparam reg_idx_t REG_MODE      = 3'd0;
  localparam reg_idx_t REG_LOW_THR   = 3'd1;
  localparam reg_idx_t REG_HIGH_THR  = 3'd2;
  localparam reg_idx_t REG_ZONE1_CNT = 3'd3;
  localparam reg_idx_t REG_OTHER_CNT = 3'd4;

  localparam run_t ZONE1_CNT_RST = 5'd20;
  localparam run_t OTHER_CNT_RST = 5'd10;

  typedef struct packed {
    mode_t mode;
    thr_t  low_thr;
    thr_t  high_thr;
    run_t  zone1_cnt;
    run_t  other_cnt;
  } cfg_t;

  typedef struct packed {
    logic ready;
    logic chop;
  } acc_flags_t;

  typedef struct packed {
    logic first;
    logic second;
  } led_t;

endpackage

/* src/aazd_accum.sv */
// ----------------------------------------------------------------------------
// aazd_accum
// Sample accumulator: sums a run of samples, forms the average and the
// differential magnitude, and gives the chop level for the next conversion.
// ----------------------------------------------------------------------------
module aazd_accum #(
  parameter int unsigned SAMPLE_BITS   = 12,
  parameter int unsigned AVERAGE_SHIFT = 3
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  logic [SAMPLE_BITS-1:0]  sample_i,
  input  logic                    diff_i,
  output logic [SAMPLE_BITS-1:0]  avg_o,
  output aazd_pkg::avg_t          average_o,
  output aazd_pkg::acc_flags_t    flags_o
);

  localparam int unsigned SUM_W = SAMPLE_BITS + AVERAGE_SHIFT;
  localparam logic [SAMPLE_BITS-1:0] SIGN_VAL = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic [SUM_W-1:0]         sum_q, sum_d, sum_next;
  logic [AVERAGE_SHIFT-1:0] idx_q, idx_d;
  logic                     run_done;
  logic [SAMPLE_BITS-1:0]   avg;
  logic [SAMPLE_BITS-1:0]   mag;
  aazd_pkg::avg_t           result;

  assign sum_next = sum_q + SUM_W'(sample_i);
  assign run_done = (idx_q == {AVERAGE_SHIFT{1'b1}});
  assign idx_d    = step_i ? idx_q + 1'b1 : idx_q;
  assign sum_d    = step_i ? (run_done ? '0 : sum_next) : sum_q;
  assign avg      = sum_next[SUM_W-1:AVERAGE_SHIFT];

  // magnitude about mid-scale
  always_comb begin
    if (avg[SAMPLE_BITS-1]) begin
      mag = {1'b0, avg[SAMPLE_BITS-2:0]};
    end else begin
      mag = SIGN_VAL - avg;
    end
  end

  always_comb begin
    if (!run_done) begin
      result = '0;
    end else if (diff_i) begin
      result = aazd_pkg::avg_t'({mag, 1'b0});
    end else begin
      result = aazd_pkg::avg_t'(avg);
    end
  end

  assign avg_o         = avg;
  assign average_o     = result;
  assign flags_o.ready = run_done;
  // chop is high in differential mode, else it follows the low bit of the updated run position
  assign flags_o.chop  = diff_i | idx_d[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      idx_q <= '0;
    end else begin
      sum_q <= sum_d;
      idx_q <= idx_d;
    end
  end

endmodule

/* src/aazd_zone.sv */
// ----------------------------------------------------------------------------
// aazd_zone
// Zone classifier with per-zone debounce run counters and the LED state.
// ----------------------------------------------------------------------------
module aazd_zone #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic [SAMPLE_BITS-1:0] avg_i,
  input  aazd_pkg::cfg_t         cfg_i,
  output aazd_pkg::led_t         leds_o
);

  localparam int unsigned CMP_W =
    (SAMPLE_BITS > aazd_pkg::THR_W) ? SAMPLE_BITS : aazd_pkg::THR_W;

  aazd_pkg::run_t run1_q, run1_d, run2_q, run2_d, run3_q, run3_d;
  aazd_pkg::run_t inc1, inc2, inc3;
  aazd_pkg::led_t led_q, led_d;
  logic [CMP_W-1:0] avg_x, low_x, high_x;

  assign avg_x  = CMP_W'(avg_i);
  assign low_x  = CMP_W'(cfg_i.low_thr);
  assign high_x = CMP_W'(cfg_i.high_thr);
  assign inc1   = run1_q + 1'b1;
  assign inc2   = run2_q + 1'b1;
  assign inc3   = run3_q + 1'b1;

  always_comb begin
    run1_d = run1_q;
    run2_d = run2_q;
    run3_d = run3_q;
    led_d  = led_q;
    if (en_i) begin
      if (avg_x < low_x) begin
        run2_d = '0;
        run3_d = '0;
        run1_d = inc1;
        if (inc1 >= cfg_i.zone1_cnt) begin
          run1_d       = '0;
          led_d.first  = 1'b0;
          led_d.second = 1'b0;
        end
      end else if (avg_x < high_x) begin
        run1_d = '0;
        run3_d = '0;
        run2_d = inc2;
        if (inc2 >= cfg_i.other_cnt) begin
          run2_d       = '0;
          led_d.first  = 1'b1;
          led_d.second = 1'b0;
        end
      end else begin
        run1_d = '0;
        run2_d = '0;
        run3_d = inc3;
        if (inc3 >= cfg_i.other_cnt) begin
          run3_d       = '0;
          led_d.first  = 1'b0;
          led_d.second = 1'b1;
        end
      end
    end
  end

  // led state as it stands after this average
  assign leds_o = led_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run1_q <= '0;
      run2_q <= '0;
      run3_q <= '0;
      led_q  <= '0;
    end else begin
      run1_q <= run1_d;
      run2_q <= run2_d;
      run3_q <= run3_d;
      led_q  <= led_d;
    end
  end

endmodule

/* src/adc_average_zone_debounce_unit.sv */
// ----------------------------------------------------------------------------
// adc_average_zone_debounce_unit
// ADC run averager with differential magnitude and debounced zone LEDs.
// ----------------------------------------------------------------------------
// Usage:
//   samples enter on the in_ channel (valid/ready), one result leaves on the
//   out_ channel for every sample. average_ready flags the sample that closes
//   a run of 2^AVERAGE_SHIFT; average is 0 otherwise. chop_level is the level
//   for the next conversion; the LED outputs carry the state after the sample.
//   path: input register, then result register, with the single accumulate
//   / classify step between them; one sample per cycle while the receiver
//   does not stall. a stalled receiver holds the result register; the input
//   register still takes one more sample, then in_ready_o drops until the
//   result is taken. reset clears sums, run position, debounce counters,
//   LEDs and the valid bits of both register stages, and loads the register
//   defaults. the user must write the registers through the APB port only
//   while no sample is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module adc_average_zone_debounce_unit #(
  parameter int unsigned SAMPLE_BITS   = 12,
  parameter int unsigned AVERAGE_SHIFT = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // sample channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [SAMPLE_BITS-1:0]        sample_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          chop_level_o,
  output logic                          average_ready_o,
  output logic [aazd_pkg::AVG_W-1:0]    average_o,
  output logic                          led_first_o,
  output logic                          led_second_o,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [aazd_pkg::ADDR_W-1:0]   paddr,
  input  logic [aazd_pkg::DATA_W-1:0]   pwdata,
  output logic [aazd_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  aazd_pkg::cfg_t     cfg_q;
  aazd_pkg::reg_idx_t reg_idx;
  logic               wr_en;

  logic                   s1_valid_q;
  logic [SAMPLE_BITS-1:0] s1_sample_q;
  logic                   advance;
  logic                   step;

  logic [SAMPLE_BITS-1:0] avg_raw;
  aazd_pkg::avg_t         average;
  aazd_pkg::acc_flags_t   flags;
  aazd_pkg::led_t         leds;
  logic                   diff_mode;
  logic                   classify;

  logic                   out_valid_q;
  aazd_pkg::acc_flags_t   out_flags_q;
  aazd_pkg::avg_t         out_avg_q;
  aazd_pkg::led_t         out_leds_q;

  // register port
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[aazd_pkg::ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode      <= aazd_pkg::MODE_CLASSIFY;
      cfg_q.low_thr   <= '0;
      cfg_q.high_thr  <= '0;
      cfg_q.zone1_cnt <= aazd_pkg::ZONE1_CNT_RST;
      cfg_q.other_cnt <= aazd_pkg::OTHER_CNT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        aazd_pkg::REG_MODE:      cfg_q.mode      <= pwdata[aazd_pkg::MODE_W-1:0];
        aazd_pkg::REG_LOW_THR:   cfg_q.low_thr   <= pwdata[aazd_pkg::THR_W-1:0];
        aazd_pkg::REG_HIGH_THR:  cfg_q.high_thr  <= pwdata[aazd_pkg::THR_W-1:0];
        aazd_pkg::REG_ZONE1_CNT: cfg_q.zone1_cnt <= pwdata[aazd_pkg::RUN_W-1:0];
        aazd_pkg::REG_OTHER_CNT: cfg_q.other_cnt <= pwdata[aazd_pkg::RUN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      aazd_pkg::REG_MODE:      prdata = aazd_pkg::DATA_W'(cfg_q.mode);
      aazd_pkg::REG_LOW_THR:   prdata = aazd_pkg::DATA_W'(cfg_q.low_thr);
      aazd_pkg::REG_HIGH_THR:  prdata = aazd_pkg::DATA_W'(cfg_q.high_thr);
      aazd_pkg::REG_ZONE1_CNT: prdata = aazd_pkg::DATA_W'(cfg_q.zone1_cnt);
      aazd_pkg::REG_OTHER_CNT: prdata = aazd_pkg::DATA_W'(cfg_q.other_cnt);
      default:                 prdata = '0;
    endcase
  end

  // pipeline control
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;
  assign step       = s1_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_sample_q <= sample_i;
    end
  end

  assign diff_mode = (cfg_q.mode == aazd_pkg::MODE_DIFF);
  assign classify  = (cfg_q.mode == aazd_pkg::MODE_CLASSIFY);

  aazd_accum #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .AVERAGE_SHIFT (AVERAGE_SHIFT)
  ) u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .sample_i  (s1_sample_q),
    .diff_i    (diff_mode),
    .avg_o     (avg_raw),
    .average_o (average),
    .flags_o   (flags)
  );

  aazd_zone #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_zone (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (step && flags.ready && classify),
    .avg_i  (avg_raw),
    .cfg_i  (cfg_q),
    .leds_o (leds)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_leds_q  <= '0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        out_leds_q <= leds;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_flags_q <= flags;
      out_avg_q   <= average;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign chop_level_o    = out_flags_q.chop;
  assign average_ready_o = out_flags_q.ready;
  assign average_o       = out_avg_q;
  assign led_first_o     = out_leds_q.first;
  assign led_second_o    = out_leds_q.second;

  // zone patterns never light both indicators
  a_leds_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(led_first_o && led_second_o))
    else $error("both indicators set");

  // a result that does not close a run carries no average
  a_avg_zero_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !average_ready_o |-> average_o == '0)
    else $error("average set without average_ready");

  // input backpressure only when both stages are full and the sink stalls
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_o && !out_ready_i)
    else $error("input stalled without a full pipeline");

  // a result appears only from an occupied input stage
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(s1_valid_q))
    else $error("result without a sample in the input register");

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for adc_average_zone_debounce_unit.
// Samples go in through the valid/ready channel with random gaps. A bit-true
// predictor tracks run sums, averages, differential magnitudes and zone
// debounce, and every result leaving the block is compared field by field.
// Register settings change between phases through the APB port.
// ----------------------------------------------------------------------------
module tb;

  localparam int SAMPLE_W  = 12;
  localparam int AVG_SHIFT = 3;
  localparam int SUM_W     = SAMPLE_W + AVG_SHIFT;
  localparam int MAX_LEVEL = (1 << SAMPLE_W) - 1;
  localparam int N_PHASES  = 8;
  localparam int PHASE_LEN = 128;
  localparam int LONG_HOLD = 100;

  typedef struct packed {
    logic           chop;
    logic           avg_rdy;
    aazd_pkg::avg_t avg;
    logic           led1;
    logic           led2;
  } result_t;

  class avg_zone_scoreboard;
    aazd_pkg::mode_t      mode;
    aazd_pkg::thr_t       low_thr;
    aazd_pkg::thr_t       high_thr;
    aazd_pkg::run_t       zone1_lim;
    aazd_pkg::run_t       other_lim;
    logic [SUM_W-1:0]     run_sum;
    logic [AVG_SHIFT-1:0] run_pos;
    aazd_pkg::run_t       run1;
    aazd_pkg::run_t       run2;
    aazd_pkg::run_t       run3;
    logic                 led_a;
    logic                 led_b;
    result_t              pending_results[$];
    int                   errors;

    function new();
      mode      = aazd_pkg::MODE_CLASSIFY;
      low_thr   = '0;
      high_thr  = '0;
      zone1_lim = aazd_pkg::ZONE1_CNT_RST;
      other_lim = aazd_pkg::OTHER_CNT_RST;
      run_sum   = '0;
      run_pos   = '0;
      run1      = '0;
      run2      = '0;
      run3      = '0;
      led_a     = 1'b0;
      led_b     = 1'b0;
      errors    = 0;
    endfunction

    function void set_reg(aazd_pkg::reg_idx_t idx, logic [aazd_pkg::DATA_W-1:0] v);
      case (idx)
        aazd_pkg::REG_MODE:      mode      = v[aazd_pkg::MODE_W-1:0];
        aazd_pkg::REG_LOW_THR:   low_thr   = v[aazd_pkg::THR_W-1:0];
        aazd_pkg::REG_HIGH_THR:  high_thr  = v[aazd_pkg::THR_W-1:0];
        aazd_pkg::REG_ZONE1_CNT: zone1_lim = v[aazd_pkg::RUN_W-1:0];
        aazd_pkg::REG_OTHER_CNT: other_lim = v[aazd_pkg::RUN_W-1:0];
        default: ;
      endcase
    endfunction

    function void add_sample(logic [SAMPLE_W-1:0] s);
      result_t        r;
      aazd_pkg::avg_t a;
      a = '0;
      run_sum = run_sum + SUM_W'(s);
      run_pos = run_pos + 1'b1;
      r.avg_rdy = (run_pos == '0);
      if (r.avg_rdy) begin
        a = aazd_pkg::avg_t'(run_sum >> AVG_SHIFT);
        run_sum = '0;
        if (mode == aazd_pkg::MODE_DIFF) begin
          // magnitude around mid-scale, then doubled
          if (a[SAMPLE_W-1]) a[SAMPLE_W-1] = 1'b0;
          else a = aazd_pkg::avg_t'(1 << (SAMPLE_W-1)) - a;
          a = a << 1;
        end else if (mode == aazd_pkg::MODE_CLASSIFY) begin
          if (a < low_thr) begin
            run2 = '0;
            run3 = '0;
            run1 = run1 + 1'b1;
            if (run1 >= zone1_lim) begin
              run1  = '0;
              led_a = 1'b0;
              led_b = 1'b0;
            end
          end else if (a < high_thr) begin
            run1 = '0;
            run3 = '0;
            run2 = run2 + 1'b1;
            if (run2 >= other_lim) begin
              run2  = '0;
              led_a = 1'b1;
              led_b = 1'b0;
            end
          end else begin
            run1 = '0;
            run2 = '0;
            run3 = run3 + 1'b1;
            if (run3 >= other_lim) begin
              run3  = '0;
              led_a = 1'b0;
              led_b = 1'b1;
            end
          end
        end
      end
      r.avg  = a;
      r.chop = (mode == aazd_pkg::MODE_DIFF) ? 1'b1 : run_pos[0];
      r.led1 = led_a;
      r.led2 = led_b;
      pending_results.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (pending_results.size() == 0) begin
        $error("result transfer with no sample waiting");
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      if (got.chop != exp.chop) begin
        $error("chop_level: expected %0d, got %0d", exp.chop, got.chop);
        errors++;
      end
      if (got.avg_rdy != exp.avg_rdy) begin
        $error("average_ready: expected %0d, got %0d", exp.avg_rdy, got.avg_rdy);
        errors++;
      end
      if (got.avg != exp.avg) begin
        $error("average: expected 0x%0h, got 0x%0h", exp.avg, got.avg);
        errors++;
      end
      if (got.led1 != exp.led1) begin
        $error("led_first: expected %0d, got %0d", exp.led1, got.led1);
        errors++;
      end
      if (got.led2 != exp.led2) begin
        $error("led_second: expected %0d, got %0d", exp.led2, got.led2);
        errors++;
      end
    endfunction
  endclass

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_ready_o;
  logic [SAMPLE_W-1:0]           sample_i    = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic                          chop_level_o;
  logic                          average_ready_o;
  logic [aazd_pkg::AVG_W-1:0]    average_o;
  logic                          led_first_o;
  logic                          led_second_o;
  logic                          psel        = 1'b0;
  logic                          penable     = 1'b0;
  logic                          pwrite      = 1'b0;
  logic [aazd_pkg::ADDR_W-1:0]   paddr       = '0;
  logic [aazd_pkg::DATA_W-1:0]   pwdata      = '0;
  logic [aazd_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  avg_zone_scoreboard averager = new();

  bit idle_on   = 1'b1;
  bit stall_req = 1'b0;
  int sent      = 0;
  int lo_thr    = 0;
  int hi_thr    = 0;

  adc_average_zone_debounce_unit #(
    .SAMPLE_BITS  (SAMPLE_W),
    .AVERAGE_SHIFT(AVG_SHIFT)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .chop_level_o   (chop_level_o),
    .average_ready_o(average_ready_o),
    .average_o      (average_o),
    .led_first_o    (led_first_o),
    .led_second_o   (led_second_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk_i = ~clk_i;

  // transfers on both channels, seen with pre-edge values
  always @(posedge clk_i) begin : watch
    result_t got;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) averager.add_sample(sample_i);
      if (out_valid_o && out_ready_i) begin
        got.chop    = chop_level_o;
        got.avg_rdy = average_ready_o;
        got.avg     = average_o;
        got.led1    = led_first_o;
        got.led2    = led_second_o;
        averager.check_result(got);
      end
    end
  end

  // result side back-pressure
  initial begin
    forever begin
      @(posedge clk_i);
      if (stall_req) begin
        stall_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // upper bits above the register width are junk and must be dropped
  function automatic logic [aazd_pkg::DATA_W-1:0] with_junk(int w, int val);
    return (aazd_pkg::DATA_W'($urandom) << w) | aazd_pkg::DATA_W'(val);
  endfunction

  function automatic int pick_level(int zone);
    int top;
    top = (hi_thr > lo_thr) ? hi_thr : lo_thr;
    if (zone == 0 && lo_thr > 0)
      return $urandom_range(0, ((lo_thr > MAX_LEVEL) ? MAX_LEVEL + 1 : lo_thr) - 1);
    if (zone == 1 && hi_thr > lo_thr && lo_thr <= MAX_LEVEL)
      return $urandom_range(lo_thr, ((hi_thr > MAX_LEVEL) ? MAX_LEVEL + 1 : hi_thr) - 1);
    if (zone == 2 && top <= MAX_LEVEL)
      return $urandom_range(top, MAX_LEVEL);
    return $urandom_range(0, MAX_LEVEL);
  endfunction

  task automatic write_reg(aazd_pkg::reg_idx_t idx, logic [aazd_pkg::DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    averager.set_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_sample(logic [SAMPLE_W-1:0] s);
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  // stop offering and let every pending result come out
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (averager.pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  initial begin
    int zone;
    int level;
    int v;
    bit noisy;
    aazd_pkg::mode_t m;
    zone  = 2;
    level = 0;
    noisy = 1'b0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full-scale input lands in zone two; zero limits fire at once
    write_reg(aazd_pkg::REG_MODE, with_junk(aazd_pkg::MODE_W, aazd_pkg::MODE_CLASSIFY));
    write_reg(aazd_pkg::REG_LOW_THR, with_junk(aazd_pkg::THR_W, 2048));
    write_reg(aazd_pkg::REG_HIGH_THR, with_junk(aazd_pkg::THR_W, 8191));
    write_reg(aazd_pkg::REG_ZONE1_CNT, with_junk(aazd_pkg::RUN_W, 0));
    write_reg(aazd_pkg::REG_OTHER_CNT, with_junk(aazd_pkg::RUN_W, 0));
    repeat (8) send_sample('0 - 1'b1);
    drain();

    // zero input gives the largest differential magnitude
    write_reg(aazd_pkg::REG_MODE, with_junk(aazd_pkg::MODE_W, aazd_pkg::MODE_DIFF));
    repeat (8) send_sample('0);
    // switch to the unused mode code halfway through a run
    repeat (4) send_sample('0 - 1'b1);
    drain();
    write_reg(aazd_pkg::REG_MODE, with_junk(aazd_pkg::MODE_W, 3));
    repeat (4) send_sample('0 - 1'b1);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      idle_on = (ph != N_PHASES - 1);
      m = (ph < 4) ? aazd_pkg::mode_t'(ph) : aazd_pkg::mode_t'($urandom_range(0, 3));
      if (ph >= 4 && $urandom_range(0, 1) == 0) m = aazd_pkg::MODE_CLASSIFY;
      if (ph == 1) begin
        lo_thr = 0;
        hi_thr = 8191;
      end else if ($urandom_range(0, 7) == 0) begin
        lo_thr = $urandom_range(0, 8191);
        hi_thr = $urandom_range(0, 8191);
      end else begin
        lo_thr = $urandom_range(0, MAX_LEVEL);
        hi_thr = $urandom_range(0, MAX_LEVEL);
        // leave the pair crossed now and then so zone two is empty
        if (lo_thr > hi_thr && $urandom_range(0, 3) != 0) begin
          v = lo_thr;
          lo_thr = hi_thr;
          hi_thr = v;
        end
      end
      write_reg(aazd_pkg::REG_MODE, with_junk(aazd_pkg::MODE_W, m));
      write_reg(aazd_pkg::REG_LOW_THR, with_junk(aazd_pkg::THR_W, lo_thr));
      write_reg(aazd_pkg::REG_HIGH_THR, with_junk(aazd_pkg::THR_W, hi_thr));
      write_reg(aazd_pkg::REG_ZONE1_CNT, with_junk(aazd_pkg::RUN_W,
                (ph == 1) ? 31 : (ph == 5) ? 0 : $urandom_range(1, 6)));
      write_reg(aazd_pkg::REG_OTHER_CNT, with_junk(aazd_pkg::RUN_W,
                (ph == 1) ? 31 : $urandom_range(1, 6)));
      if (ph == 3) stall_req = 1'b1;
      for (int k = 0; k < PHASE_LEN; k++) begin
        // a new level at each run boundary, mostly in the same zone
        if (sent % (1 << AVG_SHIFT) == 0) begin
          if ($urandom_range(0, 3) == 0) zone = $urandom_range(0, 2);
          noisy = ($urandom_range(0, 7) == 0);
          level = pick_level(zone);
        end
        if (noisy) begin
          v = $urandom_range(0, MAX_LEVEL);
        end else begin
          v = level + $urandom_range(0, 15) - 8;
          if (v < 0) v = 0;
          if (v > MAX_LEVEL) v = MAX_LEVEL;
        end
        send_sample(SAMPLE_W'(v));
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (averager.errors == 0 && averager.pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* filelist.f */
src/aazd_pkg.sv
src/aazd_accum.sv
src/aazd_zone.sv
src/adc_average_zone_debounce_unit.sv
bench/tb.sv
